FILE: src/awrp_pkg.sv
// ----------------------------------------------------------------------------
// awrp_pkg
// shared widths, codes and types for the area weighted random pick block
// ----------------------------------------------------------------------------
package awrp_pkg;

  // sizing
  localparam int MAX_ENTRIES   = 256;
  localparam int WEIGHT_BITS   = 32;
  localparam int FRACTION_BITS = 16;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
  localparam int PROD_W  = TOTAL_W + FRACTION_BITS;
  localparam int FRAC_W  = FRACTION_BITS + 1;

  // fixed port field widths
  localparam int OP_W     = 1;
  localparam int WEIGHT_W = 32;
  localparam int RAND_W   = 17;
  localparam int PICK_W   = 8;
  localparam int SAT_W    = (FRAC_W > RAND_W) ? FRAC_W : RAND_W;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 1'b0,
    OP_PICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCALE,
    BK_WALK
  } back_state_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e                      op;
    logic [WEIGHT_BITS-1:0]   weight;
    logic                     frac_full;
    logic [FRACTION_BITS-1:0] frac;
  } awrp_cmd_t;

endpackage

FILE: src/awrp_if.sv
// ----------------------------------------------------------------------------
// awrp channel interfaces
// valid/ready channels for request words and pick result words
// ----------------------------------------------------------------------------
interface awrp_in_if import awrp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [WEIGHT_W-1:0] weight;
  logic [RAND_W-1:0]   random_fraction;

  modport source (output valid, operation, weight, random_fraction, input ready);
  modport sink   (input valid, operation, weight, random_fraction, output ready);
endinterface

interface awrp_out_if import awrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PICK_W-1:0] picked_index;
  logic              table_empty;

  modport source (output valid, picked_index, table_empty, input ready);
  modport sink   (input valid, picked_index, table_empty, output ready);
endinterface

FILE: src/awrp_front.sv
// ----------------------------------------------------------------------------
// awrp_front
// accepts request words, decodes the operation and saturates the fraction
// ----------------------------------------------------------------------------
module awrp_front import awrp_pkg::*; (
  awrp_in_if.sink   req_i,
  input  logic      q_full_i,
  output logic      push_o,
  output awrp_cmd_t cmd_o
);

  logic [SAT_W-1:0] frac_ext;

  assign req_i.ready = ~q_full_i;
  assign push_o      = req_i.valid & ~q_full_i;

  assign frac_ext = SAT_W'(req_i.random_fraction);

  always_comb begin
    cmd_o.op     = op_e'(req_i.operation);
    cmd_o.weight = WEIGHT_BITS'(req_i.weight);
    // fractions at or above one collapse to exactly one
    if (frac_ext >= (SAT_W'(1) << FRACTION_BITS)) begin
      cmd_o.frac_full = 1'b1;
      cmd_o.frac      = '0;
    end else begin
      cmd_o.frac_full = 1'b0;
      cmd_o.frac      = FRACTION_BITS'(frac_ext);
    end
  end

endmodule

FILE: src/awrp_queue.sv
// ----------------------------------------------------------------------------
// awrp_queue
// short fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module awrp_queue import awrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  awrp_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output awrp_cmd_t pop_cmd_o
);

  awrp_cmd_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = QCNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = QCNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: src/awrp_back.sv
// ----------------------------------------------------------------------------
// awrp_back
// weight table, running total and the pick walk with its result register
// ----------------------------------------------------------------------------
module awrp_back import awrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  awrp_cmd_t  q_cmd_i,
  output logic       q_pop_o,
  awrp_out_if.source res_o
);

  logic [WEIGHT_BITS-1:0]   weight_mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0]   rd_data_q;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;

  back_state_e              state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic [TOTAL_W-1:0]       sel_q, sel_d;
  logic [TOTAL_W-1:0]       acc_q, acc_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     frac_full_q, frac_full_d;
  logic [FRACTION_BITS-1:0] frac_q, frac_d;

  logic                     out_valid_q;
  logic [PICK_W-1:0]        out_index_q;
  logic                     out_empty_q;
  logic                     out_set;
  logic [IDX_W-1:0]         out_idx;
  logic                     out_flag;

  logic [PROD_W-1:0]        prod;
  logic [TOTAL_W-1:0]       sum;
  logic [IDX_W-1:0]         last_idx;

  assign prod     = PROD_W'(frac_q) * PROD_W'(total_q);
  assign sum      = acc_q + TOTAL_W'(rd_data_q);
  assign last_idx = IDX_W'(count_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    sel_d       = sel_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    frac_full_d = frac_full_q;
    frac_d      = frac_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = IDX_W'(idx_q + 1'b1);
    out_set     = 1'b0;
    out_idx     = '0;
    out_flag    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.op == OP_APPEND) begin
            q_pop_o = 1'b1;
            // append on a full table is dropped
            if (count_q < CNT_W'(MAX_ENTRIES)) begin
              wr_en   = 1'b1;
              count_d = CNT_W'(count_q + 1'b1);
              total_d = total_q + TOTAL_W'(q_cmd_i.weight);
            end
          end else if (!out_valid_q) begin
            q_pop_o = 1'b1;
            if (count_q == '0) begin
              out_set  = 1'b1;
              out_flag = 1'b1;
            end else if (count_q == CNT_W'(1)) begin
              out_set = 1'b1;
            end else begin
              frac_full_d = q_cmd_i.frac_full;
              frac_d      = q_cmd_i.frac;
              state_d     = BK_SCALE;
            end
          end
        end
      end
      BK_SCALE: begin
        sel_d   = frac_full_q ? total_q : prod[PROD_W-1:FRACTION_BITS];
        rd_addr = '0;
        idx_d   = '0;
        acc_d   = '0;
        state_d = BK_WALK;
      end
      BK_WALK: begin
        if ((sel_q <= sum) || (idx_q == last_idx)) begin
          out_set = 1'b1;
          out_idx = idx_q;
          state_d = BK_IDLE;
        end else begin
          acc_d = sum;
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    acc_q       <= acc_d;
    idx_q       <= idx_d;
    frac_full_q <= frac_full_d;
    frac_q      <= frac_d;
    if (out_set) begin
      out_index_q <= PICK_W'(out_idx);
      out_empty_q <= out_flag;
    end
  end

  // weight table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      weight_mem[count_q[IDX_W-1:0]] <= q_cmd_i.weight;
    end
    rd_data_q <= weight_mem[rd_addr];
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.picked_index = out_index_q;
  assign res_o.table_empty  = out_empty_q;

endmodule

FILE: src/area_weighted_random_pick.sv
// ----------------------------------------------------------------------------
// area_weighted_random_pick
// roulette wheel selection over a table of appended weights
// ----------------------------------------------------------------------------
//  channel  dir  word contents
//  -------  ---  ---------------------------------------------
//  in_i     in   operation, weight, random_fraction
//  out_o    out  picked_index, table_empty (one word per pick)
//
// an append is taken in the idle state of the back end; a pick on an empty
// or one-entry table answers from the idle state, otherwise it passes the
// scale state and then walks the table entries in order in the walk state,
// one after another through the single read port of the weight table
// reset clears the entry count and total; table contents need no clearing
// a two-word queue lets requests be taken while a walk runs or a result
// waits; a pick leaves the queue only once the result register is free
// ----------------------------------------------------------------------------
module area_weighted_random_pick import awrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  awrp_in_if.sink    in_i,
  awrp_out_if.source out_o
);

  // front to queue
  logic      push;
  logic      q_full;
  awrp_cmd_t push_cmd;

  // queue to back
  logic      q_valid;
  logic      q_pop;
  awrp_cmd_t q_cmd;

  // decode and fraction saturation
  awrp_front u_front (
    .req_i    (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // decoupling queue
  awrp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // table, total and walk
  awrp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .res_o     (out_o)
  );

endmodule
